FILE: rtl/fqg_pkg.sv
`timescale 1ns / 1ps

package fqg_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RANGE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ASYM_MODE     = 3'd5;

  // Register reset values.
  localparam logic [15:0] RST_CLIP_LOW      = 16'h0000;
  localparam logic [15:0] RST_CLIP_RANGE    = 16'h0100;
  localparam logic [16:0] RST_LEVEL_COUNT   = 17'h00100;
  localparam logic [15:0] RST_LOWEST_LEVEL  = 16'hFF80;
  localparam logic [14:0] RST_HIGHEST_LEVEL = 15'h007F;

  // Fixed datapath widths that follow from the register widths.
  localparam int RANGE_W = 16;
  localparam int LVL_W   = 17;
  localparam int DEN_W   = 18;

  typedef struct packed {
    logic [15:0] clip_low;
    logic [15:0] clip_range;
    logic [16:0] level_count;
    logic [15:0] lowest_level;
    logic [14:0] highest_level;
    logic        asym_mode;
  } cfg_t;

  // Datapath operations issued by the controller, one per cycle while it is not waiting on the divider or the output.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LEVEL,
    OP_DIV_LEVEL,
    OP_TAKE_K,
    OP_MUL_KR,
    OP_DIV_Q,
    OP_TAKE_Q,
    OP_MUL_GRAD,
    OP_DIV_GRAD,
    OP_TAKE_RG,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LEVEL,
    S_DIV_LEVEL,
    S_WAIT_LEVEL,
    S_MUL_KR,
    S_DIV_Q,
    S_WAIT_Q,
    S_MUL_GRAD,
    S_DIV_GRAD,
    S_WAIT_GRAD,
    S_COMMIT
  } state_t;

endpackage

FILE: rtl/fake_quantize_with_gradients_unit.sv
`timescale 1ns / 1ps

// Fake quantizer with straight-through gradients in Q8.8. Each input beat
// carries an activation, its upstream gradient and a final-item flag; each
// yields one output beat with the quantized activation, the gradient passed
// back to the activation and, on the final item, the saturated range and
// lower-bound gradient totals (the accumulators then clear). Items are
// processed one at a time: an item is accepted only after the previous one has
// gone through three passes of a single one-bit-per-cycle divider (level index,
// level value, gradient rounding) and been committed. A finished beat waits in
// the output register while the next item is accepted. Configuration is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only while
// no item is in flight, since the block itself does not enforce it.
module fake_quantize_with_gradients_unit import fqg_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_activation,
  input  logic signed [DATA_WIDTH-1:0] in_upstream_grad,
  input  logic                         in_final_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_quantized_value,
  output logic signed [DATA_WIDTH-1:0] out_activation_grad,
  output logic signed [ACC_WIDTH-1:0]  out_range_grad_total,
  output logic signed [ACC_WIDTH-1:0]  out_low_grad_total,
  output logic                         out_totals_ready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  fqg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fqg_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fqg_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_activation        (in_activation),
    .in_upstream_grad     (in_upstream_grad),
    .in_final_item        (in_final_item),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_quantized_value  (out_quantized_value),
    .out_activation_grad  (out_activation_grad),
    .out_range_grad_total (out_range_grad_total),
    .out_low_grad_total   (out_low_grad_total),
    .out_totals_ready     (out_totals_ready)
  );

endmodule

FILE: rtl/fqg_cfg_regs.sv
`timescale 1ns / 1ps

module fqg_cfg_regs import fqg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_low      <= RST_CLIP_LOW;
      cfg_r.clip_range    <= RST_CLIP_RANGE;
      cfg_r.level_count   <= RST_LEVEL_COUNT;
      cfg_r.lowest_level  <= RST_LOWEST_LEVEL;
      cfg_r.highest_level <= RST_HIGHEST_LEVEL;
      cfg_r.asym_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_LOW:      cfg_r.clip_low      <= cfg_wdata[15:0];
        REG_CLIP_RANGE:    cfg_r.clip_range    <= cfg_wdata[15:0];
        REG_LEVEL_COUNT:   cfg_r.level_count   <= cfg_wdata[16:0];
        REG_LOWEST_LEVEL:  cfg_r.lowest_level  <= cfg_wdata[15:0];
        REG_HIGHEST_LEVEL: cfg_r.highest_level <= cfg_wdata[14:0];
        REG_ASYM_MODE:     cfg_r.asym_mode     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/fqg_divider.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module fqg_divider #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};

    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/fqg_datapath.sv
`timescale 1ns / 1ps

module fqg_datapath import fqg_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_t                         cfg,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic signed [DATA_WIDTH-1:0] in_activation,
  input  logic signed [DATA_WIDTH-1:0] in_upstream_grad,
  input  logic                         in_final_item,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_quantized_value,
  output logic signed [DATA_WIDTH-1:0] out_activation_grad,
  output logic signed [ACC_WIDTH-1:0]  out_range_grad_total,
  output logic signed [ACC_WIDTH-1:0]  out_low_grad_total,
  output logic                         out_totals_ready
);

  // Compare width for activations against the clamp bounds.
  localparam int EW    = (DATA_WIDTH > 18 ? DATA_WIDTH : 18) + 1;
  // Multiplier operands and product; the product also sizes the divider.
  localparam int MA_W  = (DATA_WIDTH > LVL_W ? DATA_WIDTH : LVL_W);
  localparam int PW    = MA_W + LVL_W;
  localparam int RG_W  = PW + 1;
  localparam int SUM_W = (ACC_WIDTH > RG_W ? ACC_WIDTH : RG_W) + 1;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN =
    {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [EW-1:0] Q_MAX =
    {{(EW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [EW-1:0] Q_MIN =
    {{(EW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  // Item and intermediate registers.
  logic signed [DATA_WIDTH-1:0] a_r, g_r;
  logic                         last_r;
  logic [PW-1:0]                prod_r;
  logic [LVL_W-1:0]             k_r;
  logic signed [EW-1:0]         q_r;
  logic signed [RG_W-1:0]       rg_r;
  logic                         gsign_r;
  logic signed [ACC_WIDTH-1:0]  acc_rg_r, acc_lg_r;

  // Result registers.
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_q_r, out_ag_r;
  logic signed [ACC_WIDTH-1:0]  out_rgt_r, out_lgt_r;
  logic                         out_tr_r;

  // Effective configuration.
  logic [RANGE_W-1:0]   r_val;
  logic [LVL_W-1:0]     n_val;
  logic [14:0]          hl_val;
  logic signed [EW-1:0] lo_ext, hi_ext, a_ext, c_ext, d_ext;
  logic                 below, above, act_in_range;

  logic signed [EW-1:0] qd;
  logic                 qd_neg;
  logic [EW-1:0]        qd_abs;
  logic                 g_neg, lw_neg;
  logic [DATA_WIDTH-1:0] g_mag;
  logic [15:0]          lw_mag;
  logic [LVL_W-1:0]     grad_b;
  logic [RANGE_W-1:0]   grad_den;
  logic                 grad_sign;

  logic [MA_W-1:0]      mul_a;
  logic [LVL_W-1:0]     mul_b;
  logic [PW-1:0]        mul_p;

  logic                 div_start;
  logic [PW-1:0]        div_num;
  logic [DEN_W-1:0]     div_den;
  logic                 div_done;
  logic [PW-1:0]        div_quo;
  logic [DEN_W-1:0]     div_rem;

  logic [LVL_W-1:0]     rem2, r17;
  logic                 round_up;
  logic [RG_W-1:0]      rg_mag;

  logic signed [SUM_W-1:0] rg_sum, lg_sum, lg_ext;
  logic signed [ACC_WIDTH-1:0] rg_sat, lg_sat;
  logic signed [DATA_WIDTH-1:0] q_sat;

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic signed [ACC_WIDTH-1:0] res;
    if (v > ACC_MAX) begin
      res = ACC_MAX[ACC_WIDTH-1:0];
    end else if (v < ACC_MIN) begin
      res = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      res = v[ACC_WIDTH-1:0];
    end
    return res;
  endfunction

  // Degenerate settings map onto their nearest legal values.
  always_comb begin
    r_val  = (cfg.clip_range == '0) ? RANGE_W'(1) : cfg.clip_range;
    n_val  = (cfg.level_count < LVL_W'(2)) ? LVL_W'(1) : cfg.level_count - 1'b1;
    hl_val = (cfg.highest_level == '0) ? 15'd1 : cfg.highest_level;
  end

  // Clamp and range classification of the held activation.
  always_comb begin
    lo_ext = EW'(signed'(cfg.clip_low));
    hi_ext = lo_ext + signed'(EW'(r_val));
    a_ext  = EW'(a_r);
    below  = a_ext < lo_ext;
    above  = a_ext > hi_ext;
    act_in_range = !below && !above;
    c_ext  = below ? lo_ext : (above ? hi_ext : a_ext);
    d_ext  = c_ext - lo_ext;
  end

  // Operands of the gradient product and its divisor.
  always_comb begin
    qd      = q_r - a_ext;
    qd_neg  = qd[EW-1];
    qd_abs  = qd_neg ? EW'(-qd) : EW'(qd);
    g_neg   = g_r[DATA_WIDTH-1];
    g_mag   = g_neg ? DATA_WIDTH'(-g_r) : DATA_WIDTH'(g_r);
    lw_neg  = cfg.lowest_level[15];
    lw_mag  = lw_neg ? 16'(~cfg.lowest_level + 1'b1) : cfg.lowest_level;
    if (above) begin
      grad_b    = LVL_W'(1);
      grad_den  = RANGE_W'(1);
      grad_sign = g_neg;
    end else if (below) begin
      grad_b    = {1'b0, lw_mag};
      grad_den  = {1'b0, hl_val};
      grad_sign = g_neg ^ lw_neg;
    end else begin
      grad_b    = {1'b0, qd_abs[15:0]};
      grad_den  = r_val;
      grad_sign = g_neg ^ qd_neg;
    end
  end

  // Shared multiplier; its product is registered before any use.
  always_comb begin
    case (cmd.op)
      OP_MUL_LEVEL: begin
        mul_a = MA_W'(d_ext[15:0]);
        mul_b = n_val;
      end
      OP_MUL_KR: begin
        mul_a = MA_W'(k_r);
        mul_b = {1'b0, r_val};
      end
      default: begin
        mul_a = MA_W'(g_mag);
        mul_b = grad_b;
      end
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // Divider operands: level index, level value, then gradient rounding.
  always_comb begin
    div_start = 1'b0;
    div_num   = prod_r;
    div_den   = DEN_W'(r_val);
    case (cmd.op)
      OP_DIV_LEVEL: begin
        div_start = 1'b1;
      end
      OP_DIV_Q: begin
        div_start = 1'b1;
        div_num   = {prod_r[PW-2:0], 1'b0} + PW'(n_val);
        div_den   = {n_val, 1'b0};
      end
      OP_DIV_GRAD: begin
        div_start = 1'b1;
        div_num   = {prod_r[PW-2:0], 1'b0} + PW'(grad_den);
        div_den   = DEN_W'({grad_den, 1'b0});
      end
      default: begin
      end
    endcase
  end

  fqg_divider #(
    .NUM_W (PW),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Rounding of quotients: ties to even for the level index.
  always_comb begin
    rem2     = {div_rem[15:0], 1'b0};
    r17      = {1'b0, r_val};
    round_up = (rem2 > r17) || ((rem2 == r17) && div_quo[0]);
    rg_mag   = RG_W'(div_quo);
  end

  // Saturating totals and the clipped quantized value.
  always_comb begin
    lg_ext = (!act_in_range && cfg.asym_mode) ? SUM_W'(g_r) : '0;
    rg_sum = SUM_W'(acc_rg_r) + SUM_W'(rg_r);
    lg_sum = SUM_W'(acc_lg_r) + lg_ext;
    rg_sat = sat_acc(rg_sum);
    lg_sat = sat_acc(lg_sum);
    if (q_r > Q_MAX) begin
      q_sat = Q_MAX[DATA_WIDTH-1:0];
    end else if (q_r < Q_MIN) begin
      q_sat = Q_MIN[DATA_WIDTH-1:0];
    end else begin
      q_sat = q_r[DATA_WIDTH-1:0];
    end
  end

  // Working registers, loaded as the controller steps through an item.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a_r    <= in_activation;
        g_r    <= in_upstream_grad;
        last_r <= in_final_item;
      end
      OP_MUL_LEVEL, OP_MUL_KR: begin
        prod_r <= mul_p;
      end
      OP_MUL_GRAD: begin
        prod_r  <= mul_p;
        gsign_r <= grad_sign;
      end
      OP_TAKE_K: begin
        k_r <= div_quo[LVL_W-1:0] + LVL_W'(round_up);
      end
      OP_TAKE_Q: begin
        q_r <= lo_ext + signed'(EW'(div_quo[LVL_W-1:0]));
      end
      OP_TAKE_RG: begin
        rg_r <= gsign_r ? -signed'(rg_mag) : signed'(rg_mag);
      end
      default: begin
      end
    endcase
  end

  // Accumulators, cleared after the final item of a tensor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_rg_r <= '0;
      acc_lg_r <= '0;
    end else if (cmd.op == OP_COMMIT) begin
      if (last_r) begin
        acc_rg_r <= '0;
        acc_lg_r <= '0;
      end else begin
        acc_rg_r <= rg_sat;
        acc_lg_r <= lg_sat;
      end
    end
  end

  // Output register; a beat is held until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_COMMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COMMIT) begin
      out_q_r   <= q_sat;
      out_ag_r  <= act_in_range ? g_r : '0;
      out_rgt_r <= last_r ? rg_sat : '0;
      out_lgt_r <= last_r ? lg_sat : '0;
      out_tr_r  <= last_r;
    end
  end

  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_quantized_value  = out_q_r;
  assign out_activation_grad  = out_ag_r;
  assign out_range_grad_total = out_rgt_r;
  assign out_low_grad_total   = out_lgt_r;
  assign out_totals_ready     = out_tr_r;

endmodule

FILE: rtl/fqg_controller.sv
`timescale 1ns / 1ps

module fqg_controller import fqg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence: level index, level value, gradient, then commit the result.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MUL_LEVEL;
        end
      end
      S_MUL_LEVEL: begin
        cmd.op    = OP_MUL_LEVEL;
        state_nxt = S_DIV_LEVEL;
      end
      S_DIV_LEVEL: begin
        cmd.op    = OP_DIV_LEVEL;
        state_nxt = S_WAIT_LEVEL;
      end
      S_WAIT_LEVEL: begin
        if (stat.div_done) begin
          cmd.op    = OP_TAKE_K;
          state_nxt = S_MUL_KR;
        end
      end
      S_MUL_KR: begin
        cmd.op    = OP_MUL_KR;
        state_nxt = S_DIV_Q;
      end
      S_DIV_Q: begin
        cmd.op    = OP_DIV_Q;
        state_nxt = S_WAIT_Q;
      end
      S_WAIT_Q: begin
        if (stat.div_done) begin
          cmd.op    = OP_TAKE_Q;
          state_nxt = S_MUL_GRAD;
        end
      end
      S_MUL_GRAD: begin
        cmd.op    = OP_MUL_GRAD;
        state_nxt = S_DIV_GRAD;
      end
      S_DIV_GRAD: begin
        cmd.op    = OP_DIV_GRAD;
        state_nxt = S_WAIT_GRAD;
      end
      S_WAIT_GRAD: begin
        if (stat.div_done) begin
          cmd.op    = OP_TAKE_RG;
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: test/tb_fake_quantize_with_gradients_unit.sv
`timescale 1ns / 1ps

module tb_fake_quantize_with_gradients_unit;
  import fqg_pkg::*;

  localparam int DW = 16;
  localparam int AW = 40;
  localparam longint ACC_MAX = (64'sd1 <<< (AW - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  typedef struct {
    logic signed [DW-1:0] quantized_value;
    logic signed [DW-1:0] activation_grad;
    logic signed [AW-1:0] range_grad_total;
    logic signed [AW-1:0] low_grad_total;
    logic                 totals_ready;
  } quant_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [DW-1:0] in_activation;
  logic signed [DW-1:0] in_upstream_grad;
  logic                 in_final_item;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] out_quantized_value;
  logic signed [DW-1:0] out_activation_grad;
  logic signed [AW-1:0] out_range_grad_total;
  logic signed [AW-1:0] out_low_grad_total;
  logic                 out_totals_ready;

  // Shadow of the register file and of the two gradient accumulators.
  cfg_t        quant_cfg;
  longint      range_grad_sum;
  longint      low_grad_sum;
  quant_beat_t pending_quant_beats[$];
  quant_beat_t oldest_beat;
  int          mismatch_count = 0;
  int          out_hold = 0;
  bit          idle_on = 1'b1;

  fake_quantize_with_gradients_unit #(
    .DATA_WIDTH(DW),
    .ACC_WIDTH (AW)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_activation       (in_activation),
    .in_upstream_grad    (in_upstream_grad),
    .in_final_item       (in_final_item),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_quantized_value (out_quantized_value),
    .out_activation_grad (out_activation_grad),
    .out_range_grad_total(out_range_grad_total),
    .out_low_grad_total  (out_low_grad_total),
    .out_totals_ready    (out_totals_ready)
  );

  always #10 clk = ~clk;

  // Division rounded to nearest, ties away from zero; den is positive.
  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = (mag * 2 + den) / (den * 2);
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic longint acc_add_sat(longint acc, longint inc);
    longint sum;
    sum = acc + inc;
    if (sum > ACC_MAX) return ACC_MAX;
    if (sum < ACC_MIN) return ACC_MIN;
    return sum;
  endfunction

  // Fake-quantizes one activation, derives its gradients and updates the totals.
  function automatic quant_beat_t quantize_item(logic signed [DW-1:0] act,
                                                logic signed [DW-1:0] grad, logic fin);
    quant_beat_t res;
    longint a, g, r, n, hl, lo, hi, c, d, prod, k, rem, q, rg, lg, ag;
    a  = act;
    g  = grad;
    r  = (quant_cfg.clip_range == 0) ? 1 : quant_cfg.clip_range;
    n  = ((quant_cfg.level_count < 2) ? 2 : quant_cfg.level_count) - 1;
    hl = (quant_cfg.highest_level == 0) ? 1 : quant_cfg.highest_level;
    lo = $signed(quant_cfg.clip_low);
    hi = lo + r;
    c  = (a < lo) ? lo : ((a > hi) ? hi : a);
    d  = c - lo;
    prod = d * n;
    k    = prod / r;
    rem  = prod % r;
    // Level index rounds to nearest with ties to even.
    if (rem * 2 > r || (rem * 2 == r && k[0])) k++;
    q = lo + (2 * k * r + n) / (2 * n);

    if (a > hi) begin
      rg = g;
      ag = 0;
      lg = quant_cfg.asym_mode ? g : 0;
    end else if (a < lo) begin
      rg = div_nearest(g * longint'($signed(quant_cfg.lowest_level)), hl);
      ag = 0;
      lg = quant_cfg.asym_mode ? g : 0;
    end else begin
      rg = div_nearest((q - a) * g, r);
      ag = g;
      lg = 0;
    end
    range_grad_sum = acc_add_sat(range_grad_sum, rg);
    low_grad_sum   = acc_add_sat(low_grad_sum, lg);

    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    res.quantized_value = q[DW-1:0];
    res.activation_grad = ag[DW-1:0];
    if (fin) begin
      res.range_grad_total = range_grad_sum[AW-1:0];
      res.low_grad_total   = low_grad_sum[AW-1:0];
      res.totals_ready     = 1'b1;
      range_grad_sum = 0;
      low_grad_sum   = 0;
    end else begin
      res.range_grad_total = '0;
      res.low_grad_total   = '0;
      res.totals_ready     = 1'b0;
    end
    return res;
  endfunction

  // Writes all six registers on consecutive cycles; the block must be idle.
  task automatic write_settings(input logic [15:0] low, input logic [15:0] span,
                                input logic [16:0] levels, input logic [15:0] lowest,
                                input logic [14:0] highest, input logic asym);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CLIP_LOW;
    cfg_wdata <= {1'b0, low};
    @(posedge clk);
    cfg_index <= REG_CLIP_RANGE;
    cfg_wdata <= {1'b0, span};
    @(posedge clk);
    cfg_index <= REG_LEVEL_COUNT;
    cfg_wdata <= levels;
    @(posedge clk);
    cfg_index <= REG_LOWEST_LEVEL;
    cfg_wdata <= {1'b0, lowest};
    @(posedge clk);
    cfg_index <= REG_HIGHEST_LEVEL;
    cfg_wdata <= {2'b00, highest};
    @(posedge clk);
    cfg_index <= REG_ASYM_MODE;
    cfg_wdata <= {16'h0000, asym};
    @(posedge clk);
    cfg_we <= 1'b0;
    quant_cfg.clip_low      = low;
    quant_cfg.clip_range    = span;
    quant_cfg.level_count   = levels;
    quant_cfg.lowest_level  = lowest;
    quant_cfg.highest_level = highest;
    quant_cfg.asym_mode     = asym;
  endtask

  // Sends one input beat after a random gap and records its expected result.
  task automatic send_item(input logic signed [DW-1:0] act, input logic signed [DW-1:0] grad,
                           input logic fin);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_activation    <= act;
    in_upstream_grad <= grad;
    in_final_item    <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_quant_beats.push_back(quantize_item(act, grad, fin));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_quant_beats.size() != 0) @(posedge clk);
  endtask

  // Reset values of all registers, with beats below, inside and above the range.
  task automatic test_reset_values();
    send_item(16'sd128, 16'sd256, 1'b0);
    send_item(-16'sd1, 16'sd100, 1'b0);
    send_item(16'sd300, -16'sd5, 1'b0);
    send_item(16'sd256, 16'sd32767, 1'b1);
    wait_drained();
  endtask

  // Widest settings and extreme field values, then a quantized value beyond the width.
  task automatic test_field_extremes();
    write_settings(16'h8000, 16'hFFFF, 17'd65536, 16'h8000, 15'd32767, 1'b1);
    send_item(-16'sd32768, -16'sd32768, 1'b0);
    send_item(16'sd32767, 16'sd32767, 1'b0);
    send_item(16'sd0, -16'sd1, 1'b0);
    send_item(-16'sd1, 16'sd1, 1'b1);
    wait_drained();
    write_settings(16'd32000, 16'd1000, 17'd2, 16'h0000, 15'd32767, 1'b0);
    send_item(16'sd32767, 16'sd1000, 1'b0);
    send_item(16'sd31999, 16'sd32767, 1'b0);
    send_item(16'sd32500, -16'sd32768, 1'b0);
    send_item(-16'sd32768, -16'sd32768, 1'b1);
    wait_drained();
  endtask

  // Three levels over a range of four: level index lands on exact ties.
  task automatic write_settings_after_drain();
    wait_drained();
    write_settings(16'd0, 16'd4, 17'd3, 16'hFFFF, 15'd3, 1'b0);
  endtask

  // Zero range, too few levels, zero highest level, and rounding ties.
  task automatic test_special_settings();
    write_settings(16'hFF00, 16'd0, 17'd0, 16'h8000, 15'd0, 1'b1);
    send_item(-16'sd256, 16'sd1234, 1'b0);
    send_item(-16'sd255, -16'sd77, 1'b0);
    send_item(-16'sd300, -16'sd32768, 1'b0);
    send_item(-16'sd254, 16'sd32767, 1'b1);
    wait_drained();
    write_settings(16'd0, 16'd4, 17'd1, 16'hFFFF, 15'd3, 1'b0);
    send_item(16'sd1, 16'sd3, 1'b0);
    write_settings_after_drain();
    for (int v = 0; v <= 4; v++) send_item(v[DW-1:0], 16'sd3, (v == 4));
    wait_drained();
  endtask

  // Drives the range total into both saturation limits.
  task automatic test_accumulator_saturation();
    write_settings(16'd0, 16'd256, 17'd256, 16'h8000, 15'd1, 1'b1);
    for (int i = 0; i < 520; i++) send_item(-16'sd32768, -16'sd32768, (i == 519));
    for (int i = 0; i < 520; i++) send_item(-16'sd32768, 16'sd32767, (i == 519));
    wait_drained();
  endtask

  // Two fixed corner settings, then random settings per phase; beats mostly inside or at the edges of the range.
  task automatic test_random_traffic();
    logic [31:0]          raw;
    logic [15:0]          low, span, lowest;
    logic [16:0]          levels;
    logic [14:0]          highest;
    logic                 asym;
    longint               lo, hi, v;
    int                   sel;
    logic signed [DW-1:0] act, grad;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        write_settings(16'h8000, 16'd1, 17'd2, 16'h0000, 15'd1, 1'b0);
      end else if (phase == 1) begin
        write_settings(16'h7FFF, 16'hFFFF, 17'd65536, 16'h8000, 15'd32767, 1'b1);
      end else begin
        raw     = $urandom;
        low     = raw[15:0];
        span    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                              : 16'($urandom_range(1, 1024));
        levels  = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(2, 65536))
                                              : 17'($urandom_range(2, 300));
        v       = -longint'($urandom_range(0, 32768));
        lowest  = v[15:0];
        highest = 15'($urandom_range(1, 32767));
        asym    = 1'($urandom_range(0, 1));
        write_settings(low, span, levels, lowest, highest, asym);
      end
      lo = $signed(quant_cfg.clip_low);
      hi = lo + quant_cfg.clip_range;
      for (int i = 0; i < 75; i++) begin
        if ($urandom_range(0, 49) == 0) idle_on = ~idle_on;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          v = lo + $urandom_range(0, quant_cfg.clip_range);
        end else if (sel < 75) begin
          case ($urandom_range(0, 3))
            0: v = lo - 1;
            1: v = lo;
            2: v = hi;
            default: v = hi + 1;
          endcase
        end else begin
          raw = $urandom;
          v   = $signed(raw[15:0]);
        end
        if (v > 32767) v = 32767;
        else if (v < -32768) v = -32768;
        act = v[DW-1:0];
        if ($urandom_range(0, 6) == 0) begin
          case ($urandom_range(0, 4))
            0: grad = -16'sd32768;
            1: grad = 16'sd32767;
            2: grad = 16'sd0;
            3: grad = -16'sd1;
            default: grad = 16'sd1;
          endcase
        end else begin
          raw  = $urandom;
          grad = raw[15:0];
        end
        send_item(act, grad, ($urandom_range(0, 19) == 0));
      end
      wait_drained();
      idle_on = 1'b1;
    end
  endtask

  // Result side: random stall per beat, then field-by-field comparison.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_quant_beats.size() == 0) begin
          $error("result beat with no item pending");
          mismatch_count++;
        end else begin
          oldest_beat = pending_quant_beats.pop_front();
          if (out_quantized_value !== oldest_beat.quantized_value) begin
            $error("quantized_value: expected %0d, got %0d",
                   oldest_beat.quantized_value, out_quantized_value);
            mismatch_count++;
          end
          if (out_activation_grad !== oldest_beat.activation_grad) begin
            $error("activation_grad: expected %0d, got %0d",
                   oldest_beat.activation_grad, out_activation_grad);
            mismatch_count++;
          end
          if (out_range_grad_total !== oldest_beat.range_grad_total) begin
            $error("range_grad_total: expected %0d, got %0d",
                   oldest_beat.range_grad_total, out_range_grad_total);
            mismatch_count++;
          end
          if (out_low_grad_total !== oldest_beat.low_grad_total) begin
            $error("low_grad_total: expected %0d, got %0d",
                   oldest_beat.low_grad_total, out_low_grad_total);
            mismatch_count++;
          end
          if (out_totals_ready !== oldest_beat.totals_ready) begin
            $error("totals_ready: expected %0d, got %0d",
                   oldest_beat.totals_ready, out_totals_ready);
            mismatch_count++;
          end
        end
        out_hold = idle_on ? $urandom_range(0, 8) : 0;
      end else if (out_valid && out_hold != 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_CLIP_LOW;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_activation    = '0;
    in_upstream_grad = '0;
    in_final_item    = 1'b0;
    quant_cfg.clip_low      = RST_CLIP_LOW;
    quant_cfg.clip_range    = RST_CLIP_RANGE;
    quant_cfg.level_count   = RST_LEVEL_COUNT;
    quant_cfg.lowest_level  = RST_LOWEST_LEVEL;
    quant_cfg.highest_level = RST_HIGHEST_LEVEL;
    quant_cfg.asym_mode     = 1'b0;
    range_grad_sum = 0;
    low_grad_sum   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_field_extremes();
    test_special_settings();
    test_accumulator_saturation();
    test_random_traffic();

    // Let any stray beat show up before the verdict.
    wait_drained();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
